>>> hdl/assert_macros.svh
// Assertion macros shared by the nibble row packer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge outside reset.
`define NRP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("nibble row packer assertion failed");

// Check that an implication holds from one edge to the next.
`define NRP_ASSERT_NEXT(lbl, clk, rst_n, cond, conseq) \
  `NRP_ASSERT(lbl, clk, rst_n, (cond) |=> (conseq))

`endif

>>> hdl/nrp_pkg.sv
// Types and constants for the nibble row packer.
package nrp_pkg;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned NIB_W    = 4;
  localparam int unsigned COL_W    = 12;
  localparam int unsigned ROW_W    = 12;
  localparam int unsigned OUT_AW   = 24;
  localparam int unsigned PITCH_W  = 13;
  localparam int unsigned CFG_DW   = 13;
  localparam int unsigned CFG_IW   = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CFG_IW-1:0] CFG_ROW_PITCH  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_ODD_START  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_KEY_ENABLE = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_KEY_INDEX  = 2'd3;

  localparam logic [PITCH_W-1:0] PITCH_RESET = 13'd1;

  typedef struct packed {
    logic [PITCH_W-1:0] row_pitch;
    logic               odd_start;
    logic               key_en;
    logic [PIX_W-1:0]   key_idx;
  } cfg_t;

  typedef struct packed {
    logic [NIB_W-1:0] nib;
    logic             keep;
    logic             first;
    logic             last;
    logic             parity;
  } pix_ctrl_t;

endpackage

>>> hdl/nrp_if.sv
// Request channels of the nibble row packer: pixel input and byte write output.
interface nrp_pix_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pixel_index;
  logic        row_first;
  logic        row_last;
  logic [11:0] start_column;
  logic [11:0] start_row;

  modport source (output valid, pixel_index, row_first, row_last, start_column, start_row,
                  input ready);
  modport sink (input valid, pixel_index, row_first, row_last, start_column, start_row,
                output ready);
endinterface

interface nrp_wr_if;
  logic        valid;
  logic        ready;
  logic [23:0] byte_address;
  logic [7:0]  write_data;
  logic [1:0]  nibble_enable;
  logic        write_last;

  modport source (output valid, byte_address, write_data, nibble_enable, write_last,
                  input ready);
  modport sink (input valid, byte_address, write_data, nibble_enable, write_last,
                output ready);
endinterface

>>> hdl/nrp_front.sv
// Front stage: key test, nibble extract, start parity and row base product.
module nrp_front #(
  parameter int unsigned ADDR_BITS  = 24,
  parameter int unsigned COORD_BITS = 12
) (
  input  nrp_pkg::cfg_t       cfg_i,
  input  logic [7:0]          pixel_index_i,
  input  logic                row_first_i,
  input  logic                row_last_i,
  input  logic [11:0]         start_column_i,
  input  logic [11:0]         start_row_i,
  output nrp_pkg::pix_ctrl_t  ctrl_o,
  output logic [ADDR_BITS-1:0] prod_o,
  output logic [ADDR_BITS-1:0] half_o
);
  import nrp_pkg::*;

  localparam int unsigned CW = (COORD_BITS < COL_W) ? COORD_BITS : COL_W;
  localparam int unsigned PW = CW + PITCH_W;

  logic [CW-1:0] col;
  logic [CW-1:0] row;
  logic [PW-1:0] prod_full;
  logic [CW:0]   col_sum;

  assign col       = start_column_i[CW-1:0];
  assign row       = start_row_i[CW-1:0];
  assign prod_full = PW'(row) * PW'(cfg_i.row_pitch);
  assign col_sum   = {1'b0, col} + {{CW{1'b0}}, cfg_i.odd_start};

  assign prod_o = ADDR_BITS'(prod_full);
  assign half_o = ADDR_BITS'(col_sum[CW:1]);

  assign ctrl_o.nib    = pixel_index_i[NIB_W-1:0];
  assign ctrl_o.keep   = !(cfg_i.key_en && (pixel_index_i == cfg_i.key_idx));
  assign ctrl_o.first  = row_first_i;
  assign ctrl_o.last   = row_last_i;
  assign ctrl_o.parity = col[0] ^ cfg_i.odd_start;

endmodule

>>> hdl/nrp_queue.sv
// Short flop queue between the front and back stages.
`include "assert_macros.svh"
module nrp_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNTW-1:0]  count_q, count_d;
  logic             push, pop;

  assign full_o     = (count_q == CNTW'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign push       = push_i && !full_o;
  assign pop        = pop_i && !empty_o;
  assign pop_data_o = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  `NRP_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNTW'(DEPTH))
  `NRP_ASSERT_NEXT(a_count_up, clk_i, rst_ni, push && !pop, count_q == $past(count_q) + 1'b1)
  `NRP_ASSERT_NEXT(a_ptr_gap, clk_i, rst_ni, push && pop, count_q == $past(count_q))

endmodule

>>> hdl/nrp_back.sv
// Back stage: row position, nibble packing and registered byte write.
`include "assert_macros.svh"
module nrp_back #(
  parameter int unsigned ADDR_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 avail_i,
  input  nrp_pkg::pix_ctrl_t   ctrl_i,
  input  logic [ADDR_BITS-1:0] prod_i,
  input  logic [ADDR_BITS-1:0] half_i,
  output logic                 pop_o,
  nrp_wr_if.source             wr
);
  import nrp_pkg::*;

  localparam int unsigned OW = (ADDR_BITS < OUT_AW) ? ADDR_BITS : OUT_AW;

  logic [ADDR_BITS-1:0] addr_q, addr_d, base;
  logic                 parity_q, parity_d, par;
  logic [7:0]           pdata_q, pdata_d, pd, pd_ins;
  logic [1:0]           pen_q, pen_d, pe, pe_ins;
  logic                 emit;
  logic                 ovalid_q, ovalid_d;
  logic [OUT_AW-1:0]    oaddr_q;
  logic [7:0]           odata_q;
  logic [1:0]           oen_q;
  logic                 olast_q;

  assign pop_o = avail_i && (!ovalid_q || wr.ready);

  always_comb begin
    base = ctrl_i.first ? (prod_i + half_i) : addr_q;
    par  = ctrl_i.first ? ctrl_i.parity : parity_q;
    pd   = ctrl_i.first ? 8'h00 : pdata_q;
    pe   = ctrl_i.first ? 2'b00 : pen_q;
    pd_ins = pd;
    pe_ins = pe;
    if (ctrl_i.keep) begin
      pd_ins = par ? {ctrl_i.nib, pd[3:0]} : {pd[7:4], ctrl_i.nib};
      pe_ins = pe | (par ? 2'b10 : 2'b01);
    end
    emit = ctrl_i.last || (par && (pe_ins != 2'b00));

    addr_d   = addr_q;
    parity_d = parity_q;
    pdata_d  = pdata_q;
    pen_d    = pen_q;
    if (pop_o) begin
      addr_d   = par ? base + 1'b1 : base;
      parity_d = !par;
      pdata_d  = (par || ctrl_i.last) ? 8'h00 : pd_ins;
      pen_d    = (par || ctrl_i.last) ? 2'b00 : pe_ins;
    end

    ovalid_d = ovalid_q && !wr.ready;
    if (pop_o && emit) begin
      ovalid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      parity_q <= 1'b0;
      pdata_q  <= '0;
      pen_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      addr_q   <= addr_d;
      parity_q <= parity_d;
      pdata_q  <= pdata_d;
      pen_q    <= pen_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      oaddr_q <= OUT_AW'(base[OW-1:0]);
      odata_q <= pd_ins;
      oen_q   <= pe_ins;
      olast_q <= ctrl_i.last;
    end
  end

  assign wr.valid         = ovalid_q;
  assign wr.byte_address  = oaddr_q;
  assign wr.write_data    = odata_q;
  assign wr.nibble_enable = oen_q;
  assign wr.write_last    = olast_q;

  `NRP_ASSERT_NEXT(a_last_emits, clk_i, rst_ni, pop_o && ctrl_i.last,
                   wr.valid && wr.write_last)
  `NRP_ASSERT_NEXT(a_last_clears, clk_i, rst_ni, pop_o && ctrl_i.last, pen_q == 2'b00)
  `NRP_ASSERT_NEXT(a_parity_flip, clk_i, rst_ni, pop_o && !ctrl_i.first,
                   parity_q != $past(parity_q))
  `NRP_ASSERT(a_data_enables, clk_i, rst_ni,
              ((pen_q[0] || pdata_q[3:0] == 4'h0) && (pen_q[1] || pdata_q[7:4] == 4'h0)))

endmodule

>>> hdl/nibble_row_packer_unit.sv
// Top level of the nibble row packer: configuration registers, front, queue and back.
// Packs a stream of 8-bit palette indices, one pixel request per cycle while ready is
// high, into byte writes for a 4-bit-per-pixel framebuffer, skipping pixels equal to the
// transparent key when enabled. A row_first request loads the byte address start_row *
// row_pitch_bytes + (start_column + odd_nibble_start) / 2; a write request leaves when a
// high nibble closes a byte holding any pixel, and always on row_last (write_last set).
// The block sustains one pixel per clock while the queue has room; a pixel passes the
// front multiply into a two-entry queue, then the back stage's pack and output register,
// which drives write valid. Configuration applies to requests accepted after the write.
module nibble_row_packer_unit #(
  parameter int unsigned ADDR_BITS  = 24,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [nrp_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [nrp_pkg::CFG_DW-1:0] cfg_data_i,
  nrp_pix_if.sink                   pix_i,
  nrp_wr_if.source                  wr_o
);
  import nrp_pkg::*;

  localparam int unsigned QW = $bits(pix_ctrl_t) + 2 * ADDR_BITS;

  cfg_t                 cfg_q;
  pix_ctrl_t            f_ctrl, b_ctrl;
  logic [ADDR_BITS-1:0] f_prod, f_half, b_prod, b_half;
  logic                 q_full, q_empty, b_pop;
  logic [QW-1:0]        q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_pitch <= PITCH_RESET;
      cfg_q.odd_start <= 1'b0;
      cfg_q.key_en    <= 1'b0;
      cfg_q.key_idx   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROW_PITCH:  cfg_q.row_pitch <= cfg_data_i[PITCH_W-1:0];
        CFG_ODD_START:  cfg_q.odd_start <= cfg_data_i[0];
        CFG_KEY_ENABLE: cfg_q.key_en    <= cfg_data_i[0];
        CFG_KEY_INDEX:  cfg_q.key_idx   <= cfg_data_i[PIX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  nrp_front #(
    .ADDR_BITS  (ADDR_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .cfg_i          (cfg_q),
    .pixel_index_i  (pix_i.pixel_index),
    .row_first_i    (pix_i.row_first),
    .row_last_i     (pix_i.row_last),
    .start_column_i (pix_i.start_column),
    .start_row_i    (pix_i.start_row),
    .ctrl_o         (f_ctrl),
    .prod_o         (f_prod),
    .half_o         (f_half)
  );

  assign pix_i.ready = !q_full;

  nrp_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (pix_i.valid),
    .push_data_i ({f_ctrl, f_prod, f_half}),
    .full_o      (q_full),
    .pop_i       (b_pop),
    .pop_data_o  (q_out),
    .empty_o     (q_empty)
  );

  assign {b_ctrl, b_prod, b_half} = q_out;

  nrp_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (!q_empty),
    .ctrl_i  (b_ctrl),
    .prod_i  (b_prod),
    .half_i  (b_half),
    .pop_o   (b_pop),
    .wr      (wr_o)
  );

endmodule
